// ===== hw/rtl/rrlp_pkg.sv =====
// Package for the reflectance line position unit.
// Holds field widths, register reset values, command and register codes, and the
// sequencer state type. It depends on nothing else.
`default_nettype none

package rrlp_pkg;

    // Field widths fixed by the item format.
    localparam int TIME_W = 12;
    localparam int PIN_W  = 5;
    localparam int POS_W  = 12;
    localparam int CFG_INDEX_W = 2;

    // Position scale and register reset values.
    localparam int SCALE         = 1000;
    localparam int TIMEOUT_RESET = 2500;
    localparam int WHITE_RESET   = 900;
    localparam int BLACK_RESET   = 1500;

    // Saturation limits of the signed position field.
    localparam int POS_MAX = 2047;
    localparam int POS_MIN = -2048;

    // Input command codes.
    typedef enum logic [0:0] {
        CMD_START = 1'b0,
        CMD_TICK  = 1'b1
    } cmd_t;

    // Configuration register indexes.
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_TIMEOUT = 2'd0,
        REG_WHITE   = 2'd1,
        REG_BLACK   = 2'd2
    } cfg_reg_t;

    // Centroid sequencer states.
    typedef enum logic [2:0] {
        CEN_IDLE,
        CEN_ACCUM,
        CEN_LOAD,
        CEN_DIVIDE,
        CEN_DONE
    } cen_state_t;

endpackage

`default_nettype wire

// ===== hw/rtl/rrlp_channels.sv =====
// Valid/ready channel interfaces of the reflectance line position unit.
// Depends on rrlp_pkg for the field widths.
`default_nettype none

// Input channel: a start or tick command with the sampled pin levels.
interface rrlp_item_if;
    logic                        valid;
    logic                        ready;
    logic                        cmd;
    logic [rrlp_pkg::PIN_W-1:0]  pin_levels;

    modport source (output valid, output cmd, output pin_levels, input ready);
    modport sink   (input valid, input cmd, input pin_levels, output ready);
endinterface

// Output channel: line flag and signed centroid position.
interface rrlp_result_if;
    logic                              valid;
    logic                              ready;
    logic                              line_found;
    logic signed [rrlp_pkg::POS_W-1:0] position;

    modport source (output valid, output line_found, output position, input ready);
    modport sink   (input valid, input line_found, input position, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/rrlp_capture.sv =====
// Discharge timing of the sensor array: elapsed counter and per-sensor capture.
// Depends on rrlp_pkg for widths and command codes.
`default_nettype none

module rrlp_capture #(
    parameter int SENSOR_COUNT = 5
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              take,
    input  wire logic                              cmd,
    input  wire logic [rrlp_pkg::PIN_W-1:0]        pin_levels,
    input  wire logic [rrlp_pkg::TIME_W-1:0]       timeout_us,
    output logic      [rrlp_pkg::TIME_W-1:0]       times [SENSOR_COUNT],
    output logic                                   finish
);

    logic [rrlp_pkg::TIME_W-1:0] elapsed_reg;
    logic                        measuring_reg;
    logic [SENSOR_COUNT-1:0]     captured_reg;
    logic [rrlp_pkg::TIME_W-1:0] times_reg [SENSOR_COUNT];

    logic [SENSOR_COUNT-1:0]     level;
    logic [SENSOR_COUNT-1:0]     captured_next;
    logic                        is_start;
    logic                        is_tick;
    logic                        ends;

    // Sensors beyond the pin field read as discharged.
    for (genvar i = 0; i < SENSOR_COUNT; i++) begin : g_level
        if (i < rrlp_pkg::PIN_W) begin : g_pin
            assign level[i] = pin_levels[i];
        end
        else begin : g_none
            assign level[i] = 1'b0;
        end
    end

    // Decode the transaction and decide whether this tick closes the measurement.
    always_comb
    begin
        is_start      = take && (cmd == rrlp_pkg::CMD_START);
        is_tick       = take && (cmd == rrlp_pkg::CMD_TICK) && measuring_reg;
        captured_next = captured_reg | ~level;
        ends          = (&captured_next) || (elapsed_reg >= timeout_us);
        finish        = is_tick && ends;
    end

    // Control state: elapsed count, capture flags and the measuring flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            elapsed_reg   <= '0;
            measuring_reg <= 1'b0;
            captured_reg  <= '0;
        end
        else if (is_start)
        begin
            elapsed_reg   <= '0;
            measuring_reg <= 1'b1;
            captured_reg  <= '0;
        end
        else if (is_tick)
        begin
            captured_reg <= captured_next;
            if (elapsed_reg != '1)
            begin
                elapsed_reg <= elapsed_reg + 1'b1;
            end
            if (ends)
            begin
                measuring_reg <= 1'b0;
            end
        end
    end

    // Discharge times: preset to the timeout, overwritten once on first low level.
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < SENSOR_COUNT; i++)
        begin
            if (is_start)
            begin
                times_reg[i] <= timeout_us;
            end
            else if (is_tick && !captured_reg[i] && !level[i])
            begin
                times_reg[i] <= elapsed_reg;
            end
        end
    end

    assign times = times_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/rrlp_centroid.sv =====
// Line flag and weighted centroid of the discharge times, computed by a small
// sequencer around one shared accumulate and restoring-divide datapath.
// Depends on rrlp_pkg for widths, constants and the state type.
`default_nettype none

module rrlp_centroid #(
    parameter int SENSOR_COUNT = 5
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                start,
    input  wire logic        [rrlp_pkg::TIME_W-1:0]  times [SENSOR_COUNT],
    input  wire logic        [rrlp_pkg::TIME_W-1:0]  white_level,
    input  wire logic        [rrlp_pkg::TIME_W-1:0]  black_level,
    output logic                                     busy,
    output logic                                     res_valid,
    input  wire logic                                res_ready,
    output logic                                     line_found,
    output logic signed      [rrlp_pkg::POS_W-1:0]   position
);

    localparam int IW     = $clog2(SENSOR_COUNT);
    localparam int TW     = rrlp_pkg::TIME_W + IW;
    localparam int AW     = rrlp_pkg::TIME_W + 2 * IW;
    localparam int DW     = AW + 10;
    localparam int QMAX   = (SENSOR_COUNT - 1) * rrlp_pkg::SCALE;
    localparam int QW     = $clog2(QMAX + 1);
    localparam int CW     = $clog2(QW);
    localparam int OFFSET = QMAX / 2;
    localparam int SW     = (QW + 2 > rrlp_pkg::POS_W + 1) ? QW + 2 : rrlp_pkg::POS_W + 1;

    rrlp_pkg::cen_state_t state_reg, state_next;

    logic [IW-1:0]               idx_reg, idx_next;
    logic [CW-1:0]               cnt_reg, cnt_next;
    logic                        found_reg;
    logic [TW-1:0]               total_reg;
    logic [AW-1:0]               asum_reg;
    logic [TW-1:0]               rem_reg;
    logic [QW-1:0]               dq_reg;
    logic                        valid_reg;
    logic                        line_reg;
    logic signed [rrlp_pkg::POS_W-1:0] pos_reg;

    logic [rrlp_pkg::TIME_W-1:0] cur_time;
    logic [rrlp_pkg::TIME_W-1:0] weight;
    logic [AW-1:0]               weight_idx;
    logic [DW-1:0]               dividend;
    logic [TW:0]                 trial;
    logic                        trial_ge;
    logic [TW-1:0]               rem_step;
    logic signed [SW-1:0]        pos_wide;
    logic signed [rrlp_pkg::POS_W-1:0] pos_sat;
    logic                        load_out;

    // Per-sensor weight for the sensor under the index.
    always_comb
    begin
        cur_time   = times[idx_reg];
        weight     = (cur_time >= white_level) ? (cur_time - white_level) : '0;
        weight_idx = AW'(weight) * AW'(idx_reg);
        dividend   = DW'(asum_reg) * DW'(rrlp_pkg::SCALE);
    end

    // One restoring division step: shift in the next dividend bit and compare.
    always_comb
    begin
        trial    = {rem_reg, dq_reg[QW-1]};
        trial_ge = trial >= {1'b0, total_reg};
        rem_step = trial_ge ? TW'(trial - {1'b0, total_reg}) : TW'(trial);
    end

    // Centre the quotient on zero and saturate to the position field.
    always_comb
    begin
        pos_wide = $signed(SW'(dq_reg)) - $signed(SW'(OFFSET));
        if (pos_wide > $signed(SW'(rrlp_pkg::POS_MAX)))
        begin
            pos_sat = rrlp_pkg::POS_W'(rrlp_pkg::POS_MAX);
        end
        else if (pos_wide < $signed(SW'(rrlp_pkg::POS_MIN)))
        begin
            pos_sat = rrlp_pkg::POS_W'(rrlp_pkg::POS_MIN);
        end
        else
        begin
            pos_sat = rrlp_pkg::POS_W'(pos_wide);
        end
    end

    // Sequencer next state.
    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        cnt_next   = cnt_reg;
        load_out   = 1'b0;
        case (state_reg)
            rrlp_pkg::CEN_IDLE:
            begin
                if (start)
                begin
                    state_next = rrlp_pkg::CEN_ACCUM;
                    idx_next   = '0;
                end
            end
            rrlp_pkg::CEN_ACCUM:
            begin
                idx_next = idx_reg + 1'b1;
                if (idx_reg == IW'(SENSOR_COUNT - 1))
                begin
                    state_next = rrlp_pkg::CEN_LOAD;
                end
            end
            rrlp_pkg::CEN_LOAD:
            begin
                cnt_next   = '0;
                state_next = (total_reg == '0) ? rrlp_pkg::CEN_DONE : rrlp_pkg::CEN_DIVIDE;
            end
            rrlp_pkg::CEN_DIVIDE:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CW'(QW - 1))
                begin
                    state_next = rrlp_pkg::CEN_DONE;
                end
            end
            rrlp_pkg::CEN_DONE:
            begin
                if (!valid_reg || res_ready)
                begin
                    load_out   = 1'b1;
                    state_next = rrlp_pkg::CEN_IDLE;
                end
            end
            default:
            begin
                state_next = rrlp_pkg::CEN_IDLE;
            end
        endcase
    end

    // Sequencer and output-valid registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rrlp_pkg::CEN_IDLE;
            idx_reg   <= '0;
            cnt_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            cnt_reg   <= cnt_next;
            if (load_out)
            begin
                valid_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    // Shared datapath: accumulate, load the divider, iterate, deliver.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            rrlp_pkg::CEN_IDLE:
            begin
                found_reg <= 1'b0;
                total_reg <= '0;
                asum_reg  <= '0;
            end
            rrlp_pkg::CEN_ACCUM:
            begin
                found_reg <= found_reg || (cur_time > black_level);
                total_reg <= total_reg + TW'(weight);
                asum_reg  <= asum_reg + weight_idx;
            end
            rrlp_pkg::CEN_LOAD:
            begin
                rem_reg <= TW'(dividend >> QW);
                dq_reg  <= dividend[QW-1:0];
            end
            rrlp_pkg::CEN_DIVIDE:
            begin
                rem_reg <= rem_step;
                dq_reg  <= {dq_reg[QW-2:0], trial_ge};
            end
            rrlp_pkg::CEN_DONE:
            begin
                if (load_out)
                begin
                    line_reg <= found_reg;
                    pos_reg  <= (found_reg && (total_reg != '0)) ? pos_sat : '0;
                end
            end
            default:
            begin
                found_reg <= found_reg;
            end
        endcase
    end

    assign busy       = (state_reg != rrlp_pkg::CEN_IDLE);
    assign res_valid  = valid_reg;
    assign line_found = line_reg;
    assign position   = pos_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/rc_reflectance_line_position_unit.sv =====
// Top level of the reflectance line position unit: configuration registers,
// discharge capture and the centroid sequencer.
// Depends on rrlp_pkg, rrlp_channels, rrlp_capture and rrlp_centroid.
//
//  Channel  Direction  Content
//  -------  ---------  ---------------------------------------------------
//  item     in         cmd (start or tick), pin_levels[4:0]
//  result   out        line_found, position (signed 12 bits)
//  cfg_*    in         write enable, register index, 12-bit data
//
// A tick that ends the measurement starts the centroid sequencer: one accumulate
// step per sensor, one load, one quotient bit per step in the shared restoring
// divider (skipped when the total weight is zero), then one delivery step.
// Item ready is low while the centroid sequencer runs; a result that is not
// taken holds the sequencer in its delivery step. Reset clears all control state.
`default_nettype none

module rc_reflectance_line_position_unit #(
    parameter int SENSOR_COUNT = 5
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    rrlp_item_if.sink                                 item,
    rrlp_result_if.source                             result,
    input  wire logic                                 cfg_write,
    input  wire logic [rrlp_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  wire logic [rrlp_pkg::TIME_W-1:0]          cfg_data
);

    logic [rrlp_pkg::TIME_W-1:0] timeout_reg;
    logic [rrlp_pkg::TIME_W-1:0] white_reg;
    logic [rrlp_pkg::TIME_W-1:0] black_reg;

    logic [rrlp_pkg::TIME_W-1:0] times [SENSOR_COUNT];
    logic                        take;
    logic                        finish;
    logic                        busy;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= rrlp_pkg::TIME_W'(rrlp_pkg::TIMEOUT_RESET);
            white_reg   <= rrlp_pkg::TIME_W'(rrlp_pkg::WHITE_RESET);
            black_reg   <= rrlp_pkg::TIME_W'(rrlp_pkg::BLACK_RESET);
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                rrlp_pkg::REG_TIMEOUT: timeout_reg <= cfg_data;
                rrlp_pkg::REG_WHITE:   white_reg   <= cfg_data;
                rrlp_pkg::REG_BLACK:   black_reg   <= cfg_data;
                default:               timeout_reg <= timeout_reg;
            endcase
        end
    end

    // An item transaction completes whenever the centroid sequencer is idle.
    assign item.ready = !busy;
    assign take       = item.valid && !busy;

    rrlp_capture #(
        .SENSOR_COUNT (SENSOR_COUNT)
    ) u_capture (
        .clk        (clk),
        .rst_n      (rst_n),
        .take       (take),
        .cmd        (item.cmd),
        .pin_levels (item.pin_levels),
        .timeout_us (timeout_reg),
        .times      (times),
        .finish     (finish)
    );

    rrlp_centroid #(
        .SENSOR_COUNT (SENSOR_COUNT)
    ) u_centroid (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (finish),
        .times       (times),
        .white_level (white_reg),
        .black_level (black_reg),
        .busy        (busy),
        .res_valid   (result.valid),
        .res_ready   (result.ready),
        .line_found  (result.line_found),
        .position    (result.position)
    );

endmodule

`default_nettype wire
